>>> sv/ked_pkg.sv
// shared types and constants for the key event detector
package ked_pkg;

  localparam int NUM_KEYS   = 3;
  localparam int TICK_STEP  = 10;
  localparam int MAX_CLICKS = 4;

  localparam int KeyW   = 2;
  localparam int TimeW  = 16;
  localparam int EdgeW  = 8;
  localparam int ClickW = 3;
  localparam int MaskW  = 5;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_DOWN  = 3'd1,
    PH_HELD  = 3'd2,
    PH_CLICK = 3'd3,
    PH_UP    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    EV_DOWN   = 3'd0,
    EV_UP     = 3'd1,
    EV_LONG   = 3'd2,
    EV_REPEAT = 3'd3,
    EV_CLICK  = 3'd4
  } ev_kind_t;

  typedef enum logic [1:0] {
    CFG_LONG_PRESS_TIME = 2'd0,
    CFG_REPEAT_PERIOD   = 2'd1,
    CFG_CLICK_TIMEOUT   = 2'd2,
    CFG_REPORT_MASK     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [TimeW-1:0] long_press_time;
    logic [TimeW-1:0] repeat_period;
    logic [TimeW-1:0] click_timeout;
    logic [MaskW-1:0] report_mask;
  } cfg_t;

  typedef struct packed {
    phase_t           phase;
    logic             last_level;
    logic             special_seen;
    logic [TimeW-1:0] hold_time;
    logic [TimeW-1:0] repeat_time;
    logic [EdgeW-1:0] edge_count;
    logic [TimeW-1:0] stable_wait;
  } key_state_t;

  typedef struct packed {
    logic              fire;
    ev_kind_t          kind;
    logic [ClickW-1:0] clicks;
  } key_event_t;

endpackage

>>> sv/ked_step.sv
// next-state and event logic for one key on one scan tick
module ked_step
  import ked_pkg::*;
(
  input  cfg_t       cfg,
  input  key_state_t cur,
  input  logic       level,
  output key_state_t nxt,
  output key_event_t ev
);

  localparam logic [TimeW:0] TickStep     = (TimeW+1)'(TICK_STEP);
  localparam logic [EdgeW-1:0] EdgeLimit  = EdgeW'(2 * MAX_CLICKS);
  localparam logic [EdgeW-1:0] EdgeMax    = {EdgeW{1'b1}};

  function automatic logic [TimeW-1:0] sat16(input logic [TimeW:0] v);
    return v[TimeW] ? {TimeW{1'b1}} : v[TimeW-1:0];
  endfunction

  logic           same;
  logic [TimeW:0] hold_sum;
  logic [TimeW:0] rep_sum;
  logic [TimeW:0] wait_sum;
  logic           raw_fire;

  assign same     = (level == cur.last_level);
  assign hold_sum = {1'b0, cur.hold_time} + TickStep;
  assign rep_sum  = {1'b0, cur.repeat_time} + TickStep;
  assign wait_sum = {1'b0, cur.stable_wait} + TickStep;

  always_comb begin
    nxt            = cur;
    nxt.last_level = level;
    raw_fire       = 1'b0;
    ev.kind        = EV_DOWN;
    ev.clicks      = '0;
    unique case (cur.phase)
      PH_IDLE: begin
        if (level) nxt.phase = PH_DOWN;
      end
      PH_DOWN: begin
        if (same) begin
          nxt.phase = PH_HELD;
          raw_fire  = 1'b1;
          ev.kind   = EV_DOWN;
        end else begin
          nxt.phase = PH_IDLE;
        end
      end
      PH_HELD: begin
        if (same) begin
          if (cfg.long_press_time != '0) begin
            if (cur.hold_time < cfg.long_press_time) begin
              nxt.hold_time = sat16(hold_sum);
              if (hold_sum >= {1'b0, cfg.long_press_time}) begin
                nxt.special_seen = 1'b1;
                raw_fire         = 1'b1;
                ev.kind          = EV_LONG;
              end
            end else if (cfg.repeat_period != '0) begin
              if (rep_sum >= {1'b0, cfg.repeat_period}) begin
                nxt.repeat_time  = '0;
                nxt.special_seen = 1'b1;
                raw_fire         = 1'b1;
                ev.kind          = EV_REPEAT;
              end else begin
                nxt.repeat_time = rep_sum[TimeW-1:0];
              end
            end
          end
        end else if (cur.special_seen) begin
          nxt.special_seen = 1'b0;
          nxt.phase        = PH_UP;
        end else begin
          nxt.phase = PH_CLICK;
        end
      end
      PH_CLICK: begin
        if (!same) begin
          if (cur.edge_count != EdgeMax) nxt.edge_count = cur.edge_count + 1'b1;
          nxt.stable_wait = '0;
        end else if (wait_sum > {1'b0, cfg.click_timeout}) begin
          if (cur.edge_count <= EdgeLimit) begin
            raw_fire  = 1'b1;
            ev.kind   = EV_CLICK;
            ev.clicks = cur.edge_count[ClickW:1];
          end
          nxt.stable_wait = '0;
          nxt.phase       = PH_UP;
        end else begin
          nxt.stable_wait = sat16(wait_sum);
        end
      end
      PH_UP: begin
        if (!level && same) begin
          raw_fire        = 1'b1;
          ev.kind         = EV_UP;
          nxt.repeat_time = '0;
          nxt.hold_time   = '0;
          nxt.edge_count  = '0;
          nxt.phase       = PH_IDLE;
        end
      end
      default: begin
        nxt.phase = PH_IDLE;
      end
    endcase
    ev.fire = raw_fire && cfg.report_mask[ev.kind];
  end

endmodule

>>> sv/key_event_detector.sv
// top level of the key event detector: per-key state, config registers, result register
//
//  channel  signals                          transaction
//  -------  -------------------------------  ------------------------------
//  s        s_tvalid s_tready s_tdata[7:0]   one scan tick of one key
//  m        m_tvalid m_tready m_tdata m_tuser one key event
//  cfg      cfg_valid cfg_ready cfg_index    one register write
//           cfg_data
//
// one scan tick per cycle while m is not stalled; the key update runs from the input to the result register
// an event appears on m the cycle after its tick is taken
// s_tready stays high while the result register is empty or being drained
// rst clears all key state and loads the register reset values
// cfg_ready is always high
module key_event_detector
  import ked_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [1:0] key_index, [2] pressed
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // [1:0] event_key, [4:2] click_number
  output logic [2:0]       m_tuser,   // [2:0] event_kind
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [TimeW-1:0] cfg_data
);

  cfg_t       cfg;
  key_state_t keys [NUM_KEYS];
  key_state_t cur;
  key_state_t nxt;
  key_event_t ev;

  logic [KeyW-1:0]   key_index;
  logic              pressed;
  logic              key_ok;
  logic              accept;
  logic [KeyW-1:0]   event_key;
  logic [ClickW-1:0] click_number;
  ev_kind_t          event_kind;

  assign key_index = s_tdata[KeyW-1:0];
  assign pressed   = s_tdata[KeyW];
  assign key_ok    = int'(key_index) < NUM_KEYS;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign cur       = key_ok ? keys[key_index] : '0;

  ked_step u_step (
    .cfg   (cfg),
    .cur   (cur),
    .level (pressed),
    .nxt   (nxt),
    .ev    (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_time <= TimeW'(1000);
      cfg.repeat_period   <= TimeW'(100);
      cfg.click_timeout   <= TimeW'(300);
      cfg.report_mask     <= MaskW'(28);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_LONG_PRESS_TIME: cfg.long_press_time <= cfg_data;
        CFG_REPEAT_PERIOD:   cfg.repeat_period   <= cfg_data;
        CFG_CLICK_TIMEOUT:   cfg.click_timeout   <= cfg_data;
        CFG_REPORT_MASK:     cfg.report_mask     <= cfg_data[MaskW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        keys[k].phase        <= PH_IDLE;
        keys[k].last_level   <= 1'b0;
        keys[k].special_seen <= 1'b0;
        keys[k].hold_time    <= '0;
        keys[k].repeat_time  <= '0;
        keys[k].edge_count   <= '0;
        keys[k].stable_wait  <= '0;
      end
    end else if (accept && key_ok) begin
      keys[key_index] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= key_ok && ev.fire;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_key    <= key_index;
      event_kind   <= ev.kind;
      click_number <= ev.clicks;
    end
  end

  assign m_tdata = {3'b000, click_number, event_key};
  assign m_tuser = event_kind;

`ifndef NO_ASSERTIONS
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= EV_CLICK))
    else $error("event kind out of range");

  a_clicks_only_multi: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != EV_CLICK) |-> (m_tdata[4:2] == '0))
    else $error("click count on a non multi-click event");

  a_clicks_bound: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == EV_CLICK) |-> (int'(m_tdata[4:2]) <= MAX_CLICKS))
    else $error("multi-click count above limit");

  a_bad_key_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && !key_ok) |=> !m_tvalid)
    else $error("event raised for a key out of range");
`endif

endmodule
